[rtl/core/mbrw_pkg.sv]
// mbrw_pkg: shared constants, result codes and the command/status structs
// of the partition walker; used by mbrw_ctrl, mbrw_dp and the top level
`default_nettype none

package mbrw_pkg;

    localparam logic [8:0] TABLE_BASE   = 9'h1be;
    localparam logic [8:0] TABLE_END    = 9'h1fe;
    localparam logic [8:0] SIG_LOW_POS  = 9'd510;
    localparam logic [8:0] SIG_HIGH_POS = 9'd511;
    localparam logic [7:0] SIG_LOW_VAL  = 8'h55;
    localparam logic [7:0] SIG_HIGH_VAL = 8'haa;

    localparam logic [7:0] EXT_CHS_RESET = 8'd5;
    localparam logic [7:0] EXT_LBA_RESET = 8'd15;

    localparam logic [1:0] CFG_EXT_CHS = 2'd0;
    localparam logic [1:0] CFG_EXT_LBA = 2'd1;

    localparam logic [1:0] RK_PART   = 2'd0;
    localparam logic [1:0] RK_READ   = 2'd1;
    localparam logic [1:0] RK_DONE   = 2'd2;
    localparam logic [1:0] RK_BADSIG = 2'd3;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    typedef struct packed {
        logic       start;
        logic       take_byte;
        logic       emit_bad;
        logic       clr_pending;
        logic       set_pending;
        logic       emit_part;
        logic       finish;
        logic [1:0] rec_idx;
    } mbrw_cmd_t;

    typedef struct packed {
        logic walk_active;
        logic past_mbr;
        logic last_byte;
        logic sig_ok;
        logic rec_zero;
        logic rec_ext;
        logic out_free;
    } mbrw_sts_t;

endpackage

`default_nettype wire

[rtl/core/mbrw_dp.sv]
// mbrw_dp: byte counter, record capture registers, walk state, config
// registers and the result register; depends on mbrw_pkg
`default_nettype none

module mbrw_dp
    import mbrw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mbrw_cmd_t   cmd,
    output mbrw_sts_t        sts,
    input  wire logic [7:0]  sector_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [7:0]       part_type,
    output logic             active,
    output logic             primary,
    output logic [31:0]      start_sector,
    output logic [31:0]      size_sectors,
    output logic [31:0]      next_sector,
    output logic             last
);

    logic [8:0]  pos_reg;
    logic        walk_active_reg;
    logic [31:0] cur_reg;
    logic [31:0] first_ebr_reg;
    logic        past_mbr_reg;
    logic [31:0] pending_reg;
    logic [7:0]  sig_low_reg;
    logic [7:0]  ext_chs_reg;
    logic [7:0]  ext_lba_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic        rec_act_reg   [4];
    logic [7:0]  rec_type_reg  [4];
    logic [31:0] rec_start_reg [4];
    logic [31:0] rec_len_reg   [4];

    logic [1:0]  result_kind_reg;
    logic [7:0]  part_type_reg;
    logic        active_reg;
    logic        primary_reg;
    logic [31:0] start_sector_reg;
    logic [31:0] size_sectors_reg;
    logic [31:0] next_sector_reg;
    logic        last_reg;

    logic        in_table;
    logic [8:0]  rel;
    logic [1:0]  cap_idx;
    logic [3:0]  cap_off;
    logic [7:0]  sel_type;
    logic [31:0] sel_start;
    logic        load_out;
    logic        pending_nz;

    assign in_table = (pos_reg >= TABLE_BASE) && (pos_reg < TABLE_END);
    assign rel      = pos_reg - TABLE_BASE;
    assign cap_idx  = rel[5:4];
    assign cap_off  = rel[3:0];

    assign sel_type   = rec_type_reg[cmd.rec_idx];
    assign sel_start  = rec_start_reg[cmd.rec_idx];
    assign pending_nz = (pending_reg != 32'd0);

    assign load_out       = cmd.start | cmd.emit_bad | cmd.emit_part | cmd.finish;
    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    assign cfg_ready = 1'b1;

    always_comb
    begin
        sts.walk_active = walk_active_reg;
        sts.past_mbr    = past_mbr_reg;
        sts.last_byte   = (pos_reg == SIG_HIGH_POS);
        sts.sig_ok      = (sig_low_reg == SIG_LOW_VAL) && (sector_byte == SIG_HIGH_VAL);
        sts.rec_zero    = (sel_type == 8'd0);
        sts.rec_ext     = (sel_type == ext_chs_reg) || (sel_type == ext_lba_reg);
        sts.out_free    = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_chs_reg <= EXT_CHS_RESET;
            ext_lba_reg <= EXT_LBA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_EXT_CHS)
                ext_chs_reg <= cfg_data;
            if (cfg_index == CFG_EXT_LBA)
                ext_lba_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= 9'd0;
            walk_active_reg <= 1'b1;
            cur_reg         <= 32'd0;
            first_ebr_reg   <= 32'd0;
            past_mbr_reg    <= 1'b0;
            pending_reg     <= 32'd0;
            sig_low_reg     <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.start)
            begin
                pos_reg         <= 9'd0;
                walk_active_reg <= 1'b1;
                cur_reg         <= 32'd0;
                first_ebr_reg   <= 32'd0;
                past_mbr_reg    <= 1'b0;
                pending_reg     <= 32'd0;
                sig_low_reg     <= 8'd0;
            end
            if (cmd.take_byte)
            begin
                pos_reg <= pos_reg + 9'd1;
                if (pos_reg == SIG_LOW_POS)
                    sig_low_reg <= sector_byte;
            end
            if (cmd.emit_bad)
                walk_active_reg <= 1'b0;
            if (cmd.clr_pending)
                pending_reg <= 32'd0;
            if (cmd.set_pending)
                pending_reg <= first_ebr_reg + sel_start;
            if (cmd.finish)
            begin
                if (pending_nz)
                begin
                    if (!past_mbr_reg)
                    begin
                        first_ebr_reg <= pending_reg;
                        past_mbr_reg  <= 1'b1;
                    end
                    cur_reg <= pending_reg;
                end
                else
                begin
                    walk_active_reg <= 1'b0;
                end
            end
        end
    end

    // record capture from the partition table bytes
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && in_table)
        begin
            if (cap_off == 4'd0)
                rec_act_reg[cap_idx] <= sector_byte[7];
            else if (cap_off == 4'd4)
                rec_type_reg[cap_idx] <= sector_byte;
            else if (cap_off[3:2] == 2'b10)
                rec_start_reg[cap_idx][{cap_off[1:0], 3'b000} +: 8] <= sector_byte;
            else if (cap_off[3:2] == 2'b11)
                rec_len_reg[cap_idx][{cap_off[1:0], 3'b000} +: 8] <= sector_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_part)
        begin
            result_kind_reg  <= RK_PART;
            part_type_reg    <= sel_type;
            active_reg       <= rec_act_reg[cmd.rec_idx];
            primary_reg      <= !past_mbr_reg;
            start_sector_reg <= cur_reg + sel_start;
            size_sectors_reg <= rec_len_reg[cmd.rec_idx];
            next_sector_reg  <= 32'd0;
            last_reg         <= 1'b0;
        end
        else if (load_out)
        begin
            part_type_reg    <= 8'd0;
            active_reg       <= 1'b0;
            primary_reg      <= 1'b0;
            start_sector_reg <= 32'd0;
            size_sectors_reg <= 32'd0;
            last_reg         <= 1'b1;
            if (cmd.start)
            begin
                result_kind_reg <= RK_READ;
                next_sector_reg <= 32'd0;
            end
            else if (cmd.emit_bad)
            begin
                result_kind_reg <= RK_BADSIG;
                next_sector_reg <= 32'd0;
            end
            else if (pending_nz)
            begin
                result_kind_reg <= RK_READ;
                next_sector_reg <= pending_reg;
            end
            else
            begin
                result_kind_reg <= RK_DONE;
                next_sector_reg <= 32'd0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = result_kind_reg;
    assign part_type    = part_type_reg;
    assign active       = active_reg;
    assign primary      = primary_reg;
    assign start_sector = start_sector_reg;
    assign size_sectors = size_sectors_reg;
    assign next_sector  = next_sector_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

[rtl/core/mbrw_ctrl.sv]
// mbrw_ctrl: state machine sequencing byte intake, the record scan and the
// closing result; drives mbrw_dp through mbrw_cmd_t, depends on mbrw_pkg
`default_nettype none

module mbrw_ctrl
    import mbrw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      kind,
    input  wire mbrw_sts_t sts,
    output mbrw_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic [1:0] last_idx;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept   = in_valid && in_ready;
    assign last_idx = sts.past_mbr ? 2'd1 : 2'd3;

    always_comb
    begin
        cmd         = '0;
        cmd.rec_idx = idx_reg;
        state_next  = state_reg;
        idx_next    = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_START)
                    begin
                        cmd.start = 1'b1;
                    end
                    else if (sts.walk_active)
                    begin
                        cmd.take_byte = 1'b1;
                        if (sts.last_byte)
                        begin
                            if (!sts.sig_ok)
                            begin
                                cmd.emit_bad = 1'b1;
                            end
                            else
                            begin
                                cmd.clr_pending = 1'b1;
                                idx_next        = 2'd0;
                                state_next      = ST_SCAN;
                            end
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (sts.out_free)
                begin
                    if (sts.rec_zero && sts.past_mbr)
                    begin
                        cmd.clr_pending = 1'b1;
                        state_next      = ST_FINAL;
                    end
                    else
                    begin
                        if (sts.rec_ext && !sts.rec_zero)
                            cmd.set_pending = 1'b1;
                        else if (!sts.rec_zero)
                            cmd.emit_part = 1'b1;
                        if (idx_reg == last_idx)
                            state_next = ST_FINAL;
                        else
                            idx_next = idx_reg + 2'd1;
                    end
                end
            end
            ST_FINAL:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mbr_ebr_partition_walker.sv]
// mbr_ebr_partition_walker: top level joining mbrw_ctrl and mbrw_dp
// depends on mbrw_pkg, mbrw_ctrl, mbrw_dp
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_ready  | kind, sector_byte
//  out      | out_valid / out_ready| result_kind, part_type, active, primary,
//           |                      | start_sector, size_sectors, next_sector, last
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// the last byte of a good sector is followed by a scan of the records
// (four in the mbr, up to two in an ebr) and then the closing result
// a held result register stalls intake, the record scan and the closing result until taken
// reset leaves the walk awaiting the mbr at sector 0; cfg_ready is always high
`default_nettype none

module mbr_ebr_partition_walker
    import mbrw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  sector_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [7:0]       part_type,
    output logic             active,
    output logic             primary,
    output logic [31:0]      start_sector,
    output logic [31:0]      size_sectors,
    output logic [31:0]      next_sector,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    mbrw_cmd_t cmd;
    mbrw_sts_t sts;

    mbrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .sts      (sts),
        .cmd      (cmd)
    );

    mbrw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .sector_byte  (sector_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .part_type    (part_type),
        .active       (active),
        .primary      (primary),
        .start_sector (start_sector),
        .size_sectors (size_sectors),
        .next_sector  (next_sector),
        .last         (last)
    );

`ifndef SYNTHESIS
    a_scan_blocks_intake: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == KIND_BYTE && sts.walk_active
            && sts.last_byte && sts.sig_ok) |=> !in_ready)
        else $error("intake not blocked during record scan");

    a_last_marks_closing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((result_kind == RK_PART) != last))
        else $error("last flag does not match result kind");

    a_non_part_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind != RK_PART) |->
            (start_sector == 32'd0 && size_sectors == 32'd0 && part_type == 8'd0))
        else $error("partition fields not cleared in non-partition result");
`endif

endmodule

`default_nettype wire
